/* rtl/core/uts_pkg.sv */
// shared types, constants and scoring function for the utf-8 text scorer
`timescale 1ns / 1ps
`default_nettype none

package uts_pkg;

  localparam int SCORE_W = 22;
  localparam int CP_W    = 21;
  localparam int DELTA_W = 7;

  localparam int DEF_MAX_STRING_BYTES = 65535;
  localparam int FIELD_HIGH           = 2097151;
  localparam int FIELD_LOW            = -2097152;

  localparam logic signed [SCORE_W-1:0] INVALID_SCORE = SCORE_W'(-100000);

  localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'('hFFFD);
  localparam logic [CP_W-1:0] CP_CJK_LO      = CP_W'('h4E00);
  localparam logic [CP_W-1:0] CP_CJK_HI      = CP_W'('h9FFF);
  localparam logic [CP_W-1:0] CP_CJK_EXT_LO  = CP_W'('h3400);
  localparam logic [CP_W-1:0] CP_CJK_EXT_HI  = CP_W'('h4DBF);
  localparam logic [CP_W-1:0] CP_KANA_LO     = CP_W'('h3040);
  localparam logic [CP_W-1:0] CP_KANA_HI     = CP_W'('h30FF);
  localparam logic [CP_W-1:0] CP_HANGUL_LO   = CP_W'('hAC00);
  localparam logic [CP_W-1:0] CP_HANGUL_HI   = CP_W'('hD7AF);
  localparam logic [CP_W-1:0] CP_FULLW_LO    = CP_W'('hFF00);
  localparam logic [CP_W-1:0] CP_FULLW_HI    = CP_W'('hFFEF);

  localparam logic [7:0] BYTE_TAB = 8'h09;

  localparam logic signed [DELTA_W-1:0] DELTA_CONTROL = -7'sd8;
  localparam logic signed [DELTA_W-1:0] DELTA_ASCII   = 7'sd1;
  localparam logic signed [DELTA_W-1:0] DELTA_BAD_CP  = -7'sd50;
  localparam logic signed [DELTA_W-1:0] DELTA_WIDE_CP = 7'sd8;
  localparam logic signed [DELTA_W-1:0] DELTA_OTHER   = 7'sd2;

  typedef struct packed {
    logic [1:0]      pending;
    logic [CP_W-1:0] cp;
    logic            failed;
  } dec_state_t;

  typedef struct packed {
    dec_state_t                 st;
    logic                       add_en;
    logic signed [DELTA_W-1:0]  delta;
  } dec_result_t;

  function automatic logic signed [DELTA_W-1:0] cp_delta(input logic [CP_W-1:0] cp);
    logic wide;
    wide = (cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
           (cp >= CP_CJK_EXT_LO && cp <= CP_CJK_EXT_HI) ||
           (cp >= CP_KANA_LO && cp <= CP_KANA_HI) ||
           (cp >= CP_HANGUL_LO && cp <= CP_HANGUL_HI) ||
           (cp >= CP_FULLW_LO && cp <= CP_FULLW_HI);
    if (cp == CP_REPLACEMENT) return DELTA_BAD_CP;
    else if (wide)            return DELTA_WIDE_CP;
    else                      return DELTA_OTHER;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/uts_decode.sv */
// utf-8 byte decoder: next decoder state and score delta for one byte
`timescale 1ns / 1ps
`default_nettype none

module uts_decode
  import uts_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  text_byte,
  output dec_result_t res
);

  logic [CP_W-1:0] cp_shift;

  // continuation bytes are taken on faith, only the low six bits count
  assign cp_shift = {cur.cp[CP_W-7:0], text_byte[5:0]};

  always_comb begin
    res        = '0;
    res.st     = cur;
    res.add_en = 1'b0;
    res.delta  = DELTA_OTHER;
    if (!cur.failed) begin
      priority if (cur.pending != 2'd0) begin
        res.st.cp      = cp_shift;
        res.st.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1) begin
          res.add_en = 1'b1;
          res.delta  = cp_delta(cp_shift);
        end
      end else if (!text_byte[7]) begin
        res.add_en = 1'b1;
        res.delta  = (text_byte < 8'h20 && text_byte != BYTE_TAB) ? DELTA_CONTROL
                                                                   : DELTA_ASCII;
      end else if (text_byte[7:5] == 3'b110) begin
        res.st.pending = 2'd1;
        res.st.cp      = CP_W'(text_byte[4:0]);
      end else if (text_byte[7:4] == 4'b1110) begin
        res.st.pending = 2'd2;
        res.st.cp      = CP_W'(text_byte[3:0]);
      end else if (text_byte[7:3] == 5'b11110) begin
        res.st.pending = 2'd3;
        res.st.cp      = CP_W'(text_byte[2:0]);
      end else begin
        res.st.failed = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8_text_scorer_unit.sv */
// top level of the utf-8 text scorer: byte stream in, one score per string out
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a string per transaction (tlast on the final byte) and
// returns one transaction per string: the saturated plausibility score, with
// tuser set and score -100000 when a bad lead byte was seen or the string
// ended inside a multi-byte sequence. One byte is accepted every clock unless
// a final byte waits on a full output register; bytes pass the input register
// and results the output register, which lets the next string stream in while
// a result waits to be taken. Decoder state and running score update per byte.
// The score clamps at the extremes reachable by MAX_STRING_BYTES bytes.
module utf8_text_scorer_unit
  import uts_pkg::*;
#(
  parameter int MAX_STRING_BYTES = DEF_MAX_STRING_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [21:0] score, [23:22] zero
  output logic        m_tuser    // invalid
);

  localparam int HI_RAW   = (MAX_STRING_BYTES * 8) / 3;
  localparam int LO_RAW   = -((MAX_STRING_BYTES * 50) / 3);
  localparam int SCORE_HI = (HI_RAW > FIELD_HIGH) ? FIELD_HIGH : HI_RAW;
  localparam int SCORE_LO = (LO_RAW < FIELD_LOW) ? FIELD_LOW : LO_RAW;
  localparam logic signed [SCORE_W:0] SAT_HI = (SCORE_W + 1)'(SCORE_HI);
  localparam logic signed [SCORE_W:0] SAT_LO = (SCORE_W + 1)'(SCORE_LO);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // decoder state
  dec_state_t                 dec_st;
  logic signed [SCORE_W-1:0]  running_score;

  // output register
  logic                       out_valid;
  logic signed [SCORE_W-1:0]  out_score;
  logic                       out_invalid;

  dec_result_t                dec_res;
  logic signed [SCORE_W:0]    sum;
  logic signed [SCORE_W-1:0]  score_next;
  logic                       advance;

  uts_decode u_decode (
    .cur       (dec_st),
    .text_byte (in_byte),
    .res       (dec_res)
  );

  // only a final byte needs room in the output register
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    sum = (SCORE_W + 1)'(running_score) + (SCORE_W + 1)'(dec_res.delta);
    priority if (!dec_res.add_en) score_next = running_score;
    else if (sum > SAT_HI)        score_next = SCORE_W'(SAT_HI);
    else if (sum < SAT_LO)        score_next = SCORE_W'(SAT_LO);
    else                          score_next = SCORE_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_st        <= '0;
      running_score <= '0;
    end else if (advance) begin
      if (in_last) begin
        dec_st        <= '0;
        running_score <= '0;
      end else begin
        dec_st        <= dec_res.st;
        running_score <= score_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      if (dec_res.st.failed || dec_res.st.pending != 2'd0) begin
        out_score   <= INVALID_SCORE;
        out_invalid <= 1'b1;
      end else begin
        out_score   <= score_next;
        out_invalid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_score};
  assign m_tuser  = out_invalid;

endmodule

`default_nettype wire

/* rtl/core/uts_checker.sv */
// port-level checker for the utf-8 text scorer and its bind
`timescale 1ns / 1ps
`default_nettype none

module uts_checker
  import uts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an invalid string always reports the fixed invalid score
  a_invalid_score: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[SCORE_W-1:0] == INVALID_SCORE)
    else $error("invalid result with wrong score");

  // a pending result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("pending result changed");

  // a new result needs an accepted final byte or a stalled input before it
  a_needs_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2) ||
                        $past(!s_tready, 1))
    else $error("result without final byte");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:22] == 2'b00)
    else $error("nonzero pad bits");

endmodule

bind utf8_text_scorer_unit uts_checker u_uts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
